[hw/rtl/rxfd_pkg.sv]
// Package for the frame deframer: codes, types and the CRC-16 byte update.
package rxfd_pkg;

    localparam int TIMER_BITS = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0]  RST_PREAMBLE = 8'd90;
    localparam logic [15:0] RST_TIMEOUT  = 16'd1000;

    typedef logic [TIMER_BITS-1:0] t_timer;

    typedef enum logic [1:0] {
        CFG_PREAMBLE = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_GARBAGE  = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_PRE   = 3'd0,
        PH_STRAY = 3'd1,
        PH_HDR   = 3'd2,
        PH_LENLO = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRCHI = 3'd5,
        PH_CRCLO = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONPROTO = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_GOOD     = 3'd2,
        EV_BADCRC   = 3'd3,
        EV_TIMEOUT  = 3'd4,
        EV_GARBAGE  = 3'd5
    } t_event;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/rx_frame_deframer_crc16.sv]
// Frame deframer with CRC-16 check, receive timeout and garbage notice.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_func, i_rx_byte
//  out     | o_out_valid| i_out_ready | o_event_kind, o_out_byte, o_last_payload,
//          |            |             | o_frame_type, o_frame_seq, o_frame_length
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls: an input register feeds the parser,
// the parser feeds one result register. A full result register that is not taken
// holds the parser item and then the input register; nothing else stalls.
// Synchronous active-low reset returns to waiting for a preamble with default
// configuration; no clearing pass.
module rx_frame_deframer_crc16
    import rxfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_last_payload,
    output logic [1:0]  o_frame_type,
    output logic [3:0]  o_frame_seq,
    output logic [9:0]  o_frame_length,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [7:0]  r_cfg_preamble;
    logic [15:0] r_cfg_timeout;
    logic        r_cfg_garbage;

    logic        r_in_valid;
    logic        r_in_func;
    logic [7:0]  r_in_byte;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_crc_hi,  n_crc_hi;
    logic [1:0]  r_type,    n_type;
    logic [3:0]  r_seq,     n_seq;
    logic [9:0]  r_len,     n_len;
    logic [9:0]  r_count,   n_count;
    t_timer      r_left,    n_left;
    logic        r_armed,   n_armed;

    logic        r_out_valid;
    t_event      r_out_kind;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [1:0]  r_out_type;
    logic [3:0]  r_out_seq;
    logic [9:0]  r_out_len;

    logic        s_out_free;
    logic        s_fire;
    logic        s_emit;
    logic        s_info;
    t_event      s_kind;
    logic [7:0]  s_byte;
    logic        s_last;
    logic [9:0]  s_count_inc;
    t_timer      s_left_dec;

    assign s_out_free  = !r_out_valid || i_out_ready;
    assign s_fire      = r_in_valid && s_out_free;
    assign o_in_ready  = !r_in_valid || s_out_free;
    assign o_cfg_ready = 1'b1;

    assign s_count_inc = r_count + 10'd1;
    assign s_left_dec  = (r_left != '0) ? t_timer'(r_left - t_timer'(1)) : r_left;

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        n_type   = r_type;
        n_seq    = r_seq;
        n_len    = r_len;
        n_count  = r_count;
        n_left   = r_left;
        n_armed  = r_armed;
        s_emit   = 1'b0;
        s_info   = 1'b0;
        s_kind   = EV_NONPROTO;
        s_byte   = 8'd0;
        s_last   = 1'b0;

        if (r_in_func) begin
            if (r_armed) begin
                n_left = s_left_dec;
                if (s_left_dec == '0) begin
                    n_armed = 1'b0;
                    n_phase = PH_PRE;
                    s_emit  = 1'b1;
                    s_info  = 1'b1;
                    s_kind  = EV_TIMEOUT;
                end
            end
        end else begin
            case (r_phase)
                PH_HDR: begin
                    n_type  = r_in_byte[7:6];
                    n_seq   = r_in_byte[5:2];
                    n_len   = {8'd0, r_in_byte[1:0]};
                    n_crc   = crc_byte(CRC_INIT, r_in_byte);
                    n_phase = (r_in_byte[1:0] == 2'd0) ? PH_CRCHI : PH_LENLO;
                end
                PH_LENLO: begin
                    n_len   = {2'(r_len[1:0] - 2'd1), r_in_byte} + 10'd1;
                    n_crc   = crc_byte(r_crc, r_in_byte);
                    n_count = 10'd0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_crc   = crc_byte(r_crc, r_in_byte);
                    n_count = s_count_inc;
                    s_last  = (s_count_inc >= r_len);
                    if (s_last) begin
                        n_phase = PH_CRCHI;
                    end
                    s_emit  = 1'b1;
                    s_info  = 1'b1;
                    s_kind  = EV_PAYLOAD;
                    s_byte  = r_in_byte;
                end
                PH_CRCHI: begin
                    n_crc_hi = r_in_byte;
                    n_phase  = PH_CRCLO;
                end
                PH_CRCLO: begin
                    n_armed = 1'b0;
                    n_phase = PH_PRE;
                    s_emit  = 1'b1;
                    s_info  = 1'b1;
                    s_kind  = ({r_crc_hi, r_in_byte} == r_crc) ? EV_GOOD : EV_BADCRC;
                end
                default: begin
                    // waiting for preamble, also after stray bytes
                    if (r_in_byte == r_cfg_preamble) begin
                        n_type  = 2'd0;
                        n_seq   = 4'd0;
                        n_len   = 10'd0;
                        n_count = 10'd0;
                        n_crc   = CRC_INIT;
                        n_left  = t_timer'(r_cfg_timeout);
                        n_armed = 1'b1;
                        n_phase = PH_HDR;
                        if (r_phase == PH_STRAY && r_cfg_garbage) begin
                            s_emit = 1'b1;
                            s_kind = EV_GARBAGE;
                        end
                    end else begin
                        n_phase = PH_STRAY;
                        s_emit  = 1'b1;
                        s_kind  = EV_NONPROTO;
                        s_byte  = r_in_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_preamble <= RST_PREAMBLE;
            r_cfg_timeout  <= RST_TIMEOUT;
            r_cfg_garbage  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PREAMBLE: r_cfg_preamble <= i_cfg_data[7:0];
                CFG_TIMEOUT:  r_cfg_timeout  <= i_cfg_data;
                CFG_GARBAGE:  r_cfg_garbage  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_func <= i_func;
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PRE;
            r_crc    <= CRC_INIT;
            r_crc_hi <= 8'd0;
            r_type   <= 2'd0;
            r_seq    <= 4'd0;
            r_len    <= 10'd0;
            r_count  <= 10'd0;
            r_left   <= '0;
            r_armed  <= 1'b0;
        end else if (s_fire) begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
            r_type   <= n_type;
            r_seq    <= n_seq;
            r_len    <= n_len;
            r_count  <= n_count;
            r_left   <= n_left;
            r_armed  <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_fire && s_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && s_emit) begin
            r_out_kind <= s_kind;
            r_out_byte <= s_byte;
            r_out_last <= s_last;
            r_out_type <= s_info ? r_type : 2'd0;
            r_out_seq  <= s_info ? r_seq : 4'd0;
            r_out_len  <= s_info ? r_len : 10'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_out_byte     = r_out_byte;
    assign o_last_payload = r_out_last;
    assign o_frame_type   = r_out_type;
    assign o_frame_seq    = r_out_seq;
    assign o_frame_length = r_out_len;

    a_armed_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_phase != PH_PRE && r_phase != PH_STRAY))
        else $error("timer armed outside a frame");

    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_count < r_len))
        else $error("payload count reached length inside data phase");

    a_last_to_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && !r_in_func && r_phase == PH_DATA && s_last) |=> (r_phase == PH_CRCHI))
        else $error("last payload item did not move to CRC phase");

    a_garbage_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == EV_GARBAGE) |->
            (r_out_seq == 4'd0 && r_out_len == 10'd0 && r_out_byte == 8'd0))
        else $error("garbage event carries frame fields");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the frame deframer: a scoreboard predicts the events and checks them.
module tb_top;
    import rxfd_pkg::*;

    typedef struct packed {
        t_event      kind;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  ftype;
        logic [3:0]  fseq;
        logic [9:0]  flen;
    } t_frame_event;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } t_rx_item;

    class deframer_scoreboard;
        logic [7:0]   preamble_cfg;
        logic [15:0]  ticks_cfg;
        logic         garbage_cfg;
        t_phase       phase;
        logic [15:0]  crc_acc;
        logic [7:0]   crc_rx_hi;
        logic [1:0]   ftype;
        logic [3:0]   fseq;
        logic [9:0]   flen;
        logic [9:0]   fcount;
        logic [15:0]  ticks_left;
        logic         armed;
        t_frame_event expected_events[$];
        int           errors;
        int           checked;
        int           kind_count[6];

        function new();
            preamble_cfg = RST_PREAMBLE;
            ticks_cfg    = RST_TIMEOUT;
            garbage_cfg  = 1'b0;
            phase        = PH_PRE;
            crc_acc      = 16'hFFFF;
            crc_rx_hi    = 8'd0;
            ftype        = 2'd0;
            fseq         = 4'd0;
            flen         = 10'd0;
            fcount       = 10'd0;
            ticks_left   = 16'd0;
            armed        = 1'b0;
            errors       = 0;
            checked      = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb  = crc[15] ^ b[i];
                crc = {crc[14:0], 1'b0};
                if (fb) crc = crc ^ 16'h1021;
            end
            return crc;
        endfunction

        function void write_reg(t_cfg_index idx, logic [15:0] d);
            case (idx)
                CFG_PREAMBLE: preamble_cfg = d[7:0];
                CFG_TIMEOUT:  ticks_cfg = d;
                CFG_GARBAGE:  garbage_cfg = d[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void push_event(t_event k, logic [7:0] d, logic last, bit with_hdr);
            t_frame_event ev;
            ev.kind  = k;
            ev.data  = d;
            ev.last  = last;
            ev.ftype = with_hdr ? ftype : 2'd0;
            ev.fseq  = with_hdr ? fseq : 4'd0;
            ev.flen  = with_hdr ? flen : 10'd0;
            expected_events.push_back(ev);
        endfunction

        function void open_frame();
            ftype      = 2'd0;
            fseq       = 4'd0;
            flen       = 10'd0;
            fcount     = 10'd0;
            crc_acc    = 16'hFFFF;
            ticks_left = ticks_cfg;
            armed      = 1'b1;
            phase      = PH_HDR;
        endfunction

        function void note_input(logic func, logic [7:0] b);
            logic last;
            if (func) begin
                if (!armed) return;
                if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
                if (ticks_left != 16'd0) return;
                armed = 1'b0;
                phase = PH_PRE;
                push_event(EV_TIMEOUT, 8'd0, 1'b0, 1'b1);
                return;
            end
            case (phase)
                PH_STRAY: begin
                    if (b == preamble_cfg) begin
                        open_frame();
                        if (garbage_cfg) push_event(EV_GARBAGE, 8'd0, 1'b0, 1'b0);
                    end else begin
                        push_event(EV_NONPROTO, b, 1'b0, 1'b0);
                    end
                end
                PH_HDR: begin
                    ftype   = b[7:6];
                    fseq    = b[5:2];
                    flen    = {8'd0, b[1:0]};
                    crc_acc = crc16_update(16'hFFFF, b);
                    phase   = (b[1:0] == 2'd0) ? PH_CRCHI : PH_LENLO;
                end
                PH_LENLO: begin
                    flen    = {flen[1:0] - 2'd1, 8'd0} + {2'b00, b} + 10'd1;
                    crc_acc = crc16_update(crc_acc, b);
                    fcount  = 10'd0;
                    phase   = PH_DATA;
                end
                PH_DATA: begin
                    crc_acc = crc16_update(crc_acc, b);
                    fcount  = fcount + 10'd1;
                    last    = (fcount >= flen);
                    if (last) phase = PH_CRCHI;
                    push_event(EV_PAYLOAD, b, last, 1'b1);
                end
                PH_CRCHI: begin
                    crc_rx_hi = b;
                    phase     = PH_CRCLO;
                end
                PH_CRCLO: begin
                    armed = 1'b0;
                    phase = PH_PRE;
                    if ({crc_rx_hi, b} == crc_acc) push_event(EV_GOOD, 8'd0, 1'b0, 1'b1);
                    else push_event(EV_BADCRC, 8'd0, 1'b0, 1'b1);
                end
                default: begin
                    if (b == preamble_cfg) begin
                        open_frame();
                    end else begin
                        phase = PH_STRAY;
                        push_event(EV_NONPROTO, b, 1'b0, 1'b0);
                    end
                end
            endcase
        endfunction

        function void report(string field, logic [15:0] exp_v, logic [15:0] got_v);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
            errors++;
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data, logic last,
                                   logic [1:0] ft, logic [3:0] fs, logic [9:0] fl);
            t_frame_event ev;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, kind %0h byte %0h", $time, kind, data);
                errors++;
                return;
            end
            ev = expected_events.pop_front();
            checked++;
            kind_count[ev.kind]++;
            if (kind !== ev.kind) report("event_kind", {13'd0, ev.kind}, {13'd0, kind});
            if (data !== ev.data) report("out_byte", {8'd0, ev.data}, {8'd0, data});
            if (last !== ev.last) report("last_payload", {15'd0, ev.last}, {15'd0, last});
            if (ft !== ev.ftype) report("frame_type", {14'd0, ev.ftype}, {14'd0, ft});
            if (fs !== ev.fseq) report("frame_seq", {12'd0, ev.fseq}, {12'd0, fs});
            if (fl !== ev.flen) report("frame_length", {6'd0, ev.flen}, {6'd0, fl});
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_out_byte;
    logic        o_last_payload;
    logic [1:0]  o_frame_type;
    logic [3:0]  o_frame_seq;
    logic [9:0]  o_frame_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_PREAMBLE;
    logic [15:0] i_cfg_data = 16'd0;

    deframer_scoreboard sb;
    t_rx_item           stim_q[$];
    int                 send_idle_pct = 38;
    int                 recv_idle_pct = 59;
    int                 items_sent = 0;
    int                 ticks_sent = 0;
    logic [7:0]         cur_preamble = RST_PREAMBLE;
    logic [15:0]        cur_timeout = RST_TIMEOUT;

    rx_frame_deframer_crc16 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_out_byte     (o_out_byte),
        .o_last_payload (o_last_payload),
        .o_frame_type   (o_frame_type),
        .o_frame_seq    (o_frame_seq),
        .o_frame_length (o_frame_length),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_event_kind, o_out_byte, o_last_payload,
                            o_frame_type, o_frame_seq, o_frame_length);
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void push_byte(input logic [7:0] b);
        t_rx_item it;
        it.func = 1'b0;
        it.data = b;
        stim_q.push_back(it);
    endfunction

    function automatic void push_tick();
        t_rx_item it;
        it.func = 1'b1;
        it.data = 8'($urandom);
        stim_q.push_back(it);
    endfunction

    function automatic void add_frame(input int len, input bit corrupt, input int tick_pct);
        logic [1:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  hdr;
        logic [7:0]  b;
        logic [15:0] crc;
        if (len == 0) begin
            hi = 2'd0;
            lo = 8'd0;
        end else begin
            hi = 2'((len - 1) / 256 + 1);
            lo = 8'((len - 1) % 256);
        end
        hdr = {2'($urandom), 4'($urandom), hi};
        push_byte(cur_preamble);
        push_byte(hdr);
        crc = deframer_scoreboard::crc16_update(16'hFFFF, hdr);
        if (hi != 2'd0) begin
            push_byte(lo);
            crc = deframer_scoreboard::crc16_update(crc, lo);
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            push_byte(b);
            crc = deframer_scoreboard::crc16_update(crc, b);
            if ($urandom_range(99) < tick_pct) push_tick();
        end
        if (corrupt) crc = crc ^ (16'd1 << $urandom_range(15));
        push_byte(crc[15:8]);
        push_byte(crc[7:0]);
    endfunction

    function automatic void add_random_unit();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 60) begin
            n = ($urandom_range(99) < 70) ? $urandom_range(8) : $urandom_range(9, 64);
            add_frame(n, $urandom_range(99) < 15, (cur_timeout > 16'd8) ? 3 : 0);
        end else if (r < 70) begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom));
        end else if (r < 80) begin
            n = $urandom_range(1, 5);
            repeat (n) push_tick();
        end else if (r < 90) begin
            // frame cut short, then ticks that time it out only if the timeout is at most 40
            push_byte(cur_preamble);
            n = $urandom_range(1, 6);
            repeat (n) push_byte(8'($urandom));
            n = (cur_timeout <= 16'd40) ? int'(cur_timeout) : 3;
            repeat (n) push_tick();
        end else begin
            push_byte(cur_preamble);
            n = $urandom_range(1, 6);
            repeat (n) push_byte(8'($urandom));
        end
    endfunction

    task automatic send_item(input logic f, input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(f, b);
        items_sent++;
        if (f) ticks_sent++;
    endtask

    task automatic run_items();
        t_rx_item it;
        while (stim_q.size() != 0) begin
            it = stim_q.pop_front();
            send_item(it.func, it.data);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_index idx, input logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    task automatic set_config(input logic [7:0] pre, input logic [15:0] ticks,
                              input logic garbage);
        put_reg(CFG_PREAMBLE, {8'd0, pre});
        put_reg(CFG_TIMEOUT, ticks);
        put_reg(CFG_GARBAGE, {15'd0, garbage});
        i_cfg_valid  <= 1'b0;
        cur_preamble = pre;
        cur_timeout  = ticks;
    endtask

    task automatic random_segment(input int n_items, input int big_len);
        while (stim_q.size() < n_items) add_random_unit();
        if (big_len > 0) add_frame(big_len, 1'b0, 0);
        run_items();
        wait_idle();
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: stray bytes, empty frame, one-byte frame with bad CRC
        push_byte(8'h00);
        push_byte(8'hFF);
        add_frame(0, 1'b0, 0);
        add_frame(1, 1'b1, 0);
        push_tick();
        run_items();
        wait_idle();

        // garbage notice, timeout before header, timeout after the header byte, before its length byte
        set_config(8'hA5, 16'd3, 1'b1);
        push_byte(8'h00);
        push_byte(8'hA5);
        repeat (3) push_tick();
        push_byte(8'hA5);
        push_byte(8'hFF);
        repeat (3) push_tick();
        push_byte(8'h11);
        push_byte(8'hA5);
        run_items();
        wait_idle();

        set_config(8'h00, 16'hFFFF, 1'b1);
        random_segment(180, 768);
        set_config(8'hFF, 16'd1, 1'b0);
        random_segment(180, 0);

        send_idle_pct = 59;
        recv_idle_pct = 38;
        set_config(8'($urandom), 16'($urandom_range(4, 40)), 1'b1);
        random_segment(180, 0);
        set_config(8'($urandom), 16'($urandom_range(1, 65535)), 1'($urandom));
        random_segment(180, 0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'($urandom), 16'($urandom_range(2, 12)), 1'b0);
        random_segment(180, 0);
        set_config(RST_PREAMBLE, RST_TIMEOUT, 1'b0);
        random_segment(180, 0);

        $display("Sent %0d items (%0d ticks) over 8 register settings; checked %0d events.",
                 items_sent, ticks_sent, sb.checked);
        $display("Events: %0d stray, %0d payload, %0d good, %0d bad CRC,",
                 sb.kind_count[EV_NONPROTO], sb.kind_count[EV_PAYLOAD],
                 sb.kind_count[EV_GOOD], sb.kind_count[EV_BADCRC]);
        $display("        %0d timeout, %0d garbage.",
                 sb.kind_count[EV_TIMEOUT], sb.kind_count[EV_GARBAGE]);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout: %0d events still expected", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule
